[hdl/assert_macros.svh]
// Assertion macros for the checker module of this project.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/acp192_pkg.sv]
// ----------------------------------------------------------------------------
// acp192_pkg
// Types and constants of the six-word additive carry generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acp192_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWords = 6;

  // Word 0 is the most significant word of the state.
  typedef logic [WordW-1:0] word_t;
  typedef word_t [NumWords-1:0] state_t;

  typedef enum logic {
    OP_NEXT = 1'b0,
    OP_SEED = 1'b1
  } op_e;

  // Running sums of the seed steps, so that word i after seeding is the seed
  // plus entry i. These are also the reset values (seed of zero).
  localparam state_t SeedOffsets = '{
    32'h6FDF3B64,  // word 5
    32'h9E353F7D,  // word 4
    32'h0702C49C,  // word 3
    32'hC624DD2F,  // word 2
    32'h883126E9,  // word 1
    32'hF22D0E56   // word 0
  };

endpackage

[hdl/additive_carry_prng_192.sv]
// ----------------------------------------------------------------------------
// additive_carry_prng_192
// Six-word additive pseudo-random generator with carry, stream interface.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes commands. s_axis_tuser selects the operation:
//   0 produces the next number, 1 loads the state from the seed word in
//   s_axis_tdata. A seed transfer gives no result.
//   The master channel returns one signed 32-bit random word for each next
//   command, in command order.
//   A next command's result is registered and shown on the master channel
//   in the cycle after the command is accepted.
//   Throughput: one command per cycle while no result is stalled. The state
//   updates at acceptance: one fold-and-increment pass, or a seed load.
//   A single output register parts the two sides: while it holds a word
//   that the receiver has not taken, s_axis_tready drops; it rises again in
//   the cycle the receiver takes the word, so a command can be accepted in
//   that same cycle.
//   Reset puts the state at the value that a seed of zero gives and empties
//   the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module additive_carry_prng_192
  import acp192_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
  input  logic        s_axis_tuser,   // [0] operation
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] random_word (signed)
);

  state_t state_q, state_d;
  state_t state_next;
  state_t state_seeded;
  logic   out_valid_q, out_valid_d;
  logic signed [WordW-1:0] out_word_q, out_word_d;
  logic   in_xfer;
  logic   is_next;

  acp192_step u_step (
    .state_i (state_q),
    .state_o (state_next)
  );

  // Seeding adds the seed to each precomputed running sum.
  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      state_seeded[i] = s_axis_tdata + SeedOffsets[i];
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign is_next       = (op_e'(s_axis_tuser) == OP_NEXT);

  // State and output register update.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_word_d  = out_word_q;
    if (in_xfer) begin
      if (is_next) begin
        state_d     = state_next;
        out_valid_d = 1'b1;
        out_word_d  = state_next[0];
      end else begin
        state_d = state_seeded;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SeedOffsets;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;

endmodule

[hdl/acp192_step.sv]
// ----------------------------------------------------------------------------
// acp192_step
// Next-state logic: cascading fold with carry, then 192-bit increment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acp192_step
  import acp192_pkg::*;
(
  input  state_t state_i,
  output state_t state_o
);

  state_t             fold;
  logic [WordW:0]     sum4;
  logic [WordW+1:0]   sum3;
  logic [WordW+1:0]   sum2;
  logic [WordW+1:0]   sum1;
  logic [1:0]         carry3;
  logic [1:0]         carry2;
  logic [1:0]         carry1;
  logic [1:0]         carry0;
  logic [NumWords*WordW-1:0] flat;
  logic [NumWords*WordW-1:0] flat_inc;

  // Fold from word 4 upward; the carry into a word never exceeds one.
  always_comb begin
    fold    = state_i;
    sum4    = {1'b0, state_i[4]} + {1'b0, state_i[5]};
    fold[4] = sum4[WordW-1:0];
    carry3  = {1'b0, sum4[WordW]};

    sum3    = {2'b00, state_i[3]} + {2'b00, fold[4]} + {{WordW{1'b0}}, carry3};
    fold[3] = sum3[WordW-1:0];
    carry2  = sum3[WordW+1:WordW];

    sum2    = {2'b00, state_i[2]} + {2'b00, fold[3]} + {{WordW{1'b0}}, carry2};
    fold[2] = sum2[WordW-1:0];
    carry1  = sum2[WordW+1:WordW];

    sum1    = {2'b00, state_i[1]} + {2'b00, fold[2]} + {{WordW{1'b0}}, carry1};
    fold[1] = sum1[WordW-1:0];
    carry0  = sum1[WordW+1:WordW];

    // The carry out of the top word is dropped.
    fold[0] = state_i[0] + fold[1] + {{(WordW-2){1'b0}}, carry0};
  end

  // Increment the whole state as one 192-bit number, word 5 lowest.
  always_comb begin
    flat     = {fold[0], fold[1], fold[2], fold[3], fold[4], fold[5]};
    flat_inc = flat + {{(NumWords*WordW-1){1'b0}}, 1'b1};
    for (int i = 0; i < NumWords; i++) begin
      state_o[i] = flat_inc[(NumWords-1-i)*WordW +: WordW];
    end
  end

endmodule

[hdl/acp192_checker.sv]
// ----------------------------------------------------------------------------
// acp192_checker
// Port-level assertions for the additive carry generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acp192_checker
  import acp192_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic next_xfer;
  logic out_stall;

  // A next-number transfer on the command channel, and a stalled result.
  assign next_xfer = s_axis_tvalid && s_axis_tready && (op_e'(s_axis_tuser) == OP_NEXT);
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // A stalled result stays offered with the same word.
  `ACP_ASSERT_NEXT(a_hold_valid, out_stall, m_axis_tvalid, "result dropped while stalled")
  `ACP_ASSERT_NEXT(a_hold_data, out_stall, $stable(m_axis_tdata), "result changed while stalled")

  // A next-number transfer always produces a result in the following cycle.
  `ACP_ASSERT_NEXT(a_next_gives_result, next_xfer, m_axis_tvalid, "next transfer gave no result")

  // A new result appears only after a next-number transfer.
  `ACP_ASSERT_SAME(a_no_invented, $rose(m_axis_tvalid), $past(next_xfer), "result without a command")

  // Commands wait while a result is stalled in the output register.
  `ACP_ASSERT_SAME(a_stall_blocks, out_stall, !s_axis_tready, "command taken over a stall")

endmodule

bind additive_carry_prng_192 acp192_checker u_acp192_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
